// ===== src/skvt_pkg.sv =====
// Shared types, register codes and table generation for the SVM kernel value transform.
// No dependencies.
package skvt_pkg;

    typedef enum logic [1:0] {
        KIND_RBF  = 2'd0,
        KIND_POLY = 2'd1,
        KIND_SIG  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_KIND   = 2'd0,
        REG_GAMMA  = 2'd1,
        REG_COEF0  = 2'd2,
        REG_DEGREE = 2'd3
    } reg_idx_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [63:0] Q62_ONE = 64'd1 << 62;

    // Shift-subtract division, elaboration only.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        begin
            rem = '0;
            quo = '0;
            for (int b = 63; b >= 0; b--)
            begin
                rem = {rem[63:0], num[b]};
                if (rem >= {1'b0, den})
                begin
                    rem    = rem - {1'b0, den};
                    quo[b] = 1'b1;
                end
            end
            return quo;
        end
    endfunction

    function automatic logic [63:0] mulq62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        begin
            p = {64'd0, a} * {64'd0, b};
            return p[125:62];
        end
    endfunction

    // Entry i of exp(-i*h) or tanh(i*h/2), h = 16 / 2^lab, with frac fraction bits.
    function automatic logic [31:0] tab_entry(input int frac, input int lab, input int i,
                                              input bit tanh_sel);
        logic [63:0] term;
        logic [63:0] step;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] k;
        begin
            term = Q62_ONE;
            step = Q62_ONE;
            e    = Q62_ONE;
            for (k = 64'd1; term != 64'd0 && k < 64'd64; k++)
            begin
                term = udiv64(term >> (lab - 4), k);
                if (k[0])
                    step = step - term;
                else
                    step = step + term;
            end
            for (int n = 1; n <= i; n++)
                e = mulq62(e, step);
            if (!tanh_sel)
                return 32'((e + (64'd1 << (61 - frac))) >> (62 - frac));
            num = (Q62_ONE - e) >> 24;
            den = (Q62_ONE + e) >> 24;
            return 32'(udiv64((num << frac) + (den >> 1), den));
        end
    endfunction

endpackage

// ===== src/skvt_cfg_if.sv =====
// Configuration write channel: register index and data.
// Depends on skvt_pkg.
interface skvt_cfg_if;
    import skvt_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/skvt_in_if.sv =====
// Input word channel: norms, dot product and last marker.
// No dependencies.
interface skvt_in_if;
    logic               valid;
    logic               ready;
    logic        [30:0] row_norm;
    logic        [30:0] col_norm;
    logic signed [31:0] dot_value;
    logic               last_item;
    modport source (output valid, row_norm, col_norm, dot_value, last_item, input ready);
    modport sink (input valid, row_norm, col_norm, dot_value, last_item, output ready);
endinterface

// ===== src/skvt_out_if.sv =====
// Result word channel: kernel value, saturation flag, last marker.
// No dependencies.
interface skvt_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] kernel_value;
    logic               saturated;
    logic               last_out;
    modport source (output valid, kernel_value, saturated, last_out, input ready);
    modport sink (input valid, kernel_value, saturated, last_out, output ready);
endinterface

// ===== src/svm_kernel_value_transform.sv =====
// SVM kernel value transform: rbf, polynomial and sigmoid kernels in fixed point.
// Depends on skvt_pkg, skvt_cfg_if, skvt_in_if, skvt_out_if.
//
// Usage:
//   cfg    : register writes (kind, gamma, coef0, degree); always ready. Write only
//            while no word is in flight.
//   item   : one word per element (row_norm, col_norm, dot_value, last_item).
//   result : one word per input word, in order (kernel_value, saturated, last_out).
// Throughput: one word per cycle while result.ready is high; see Stall below.
// Pipeline: S0, S1, S2, a multiply chain and a result register; the
//   polynomial power takes one chain stage per multiply.
// Reset: config returns to rbf, gamma 1.0, coef0 0, degree 3; pipeline empties.
// Stall: each stage holds while the next is full and stalled; empty stages keep
//   filling, so item.ready drops only once the whole pipeline is full.
module svm_kernel_value_transform
    import skvt_pkg::*;
#(
    parameter int FRAC_BITS     = 16,
    parameter int MAX_DEGREE    = 8,
    parameter int LUT_ADDR_BITS = 8
)(
    input  logic        clk,
    input  logic        rst_n,
    skvt_cfg_if.sink    cfg,
    skvt_in_if.sink     item,
    skvt_out_if.source  result
);

    localparam int F        = FRAC_BITS;
    localparam int L        = LUT_ADDR_BITS;
    localparam int SEG      = F + 4 - L;
    localparam int FRW      = (SEG > 0) ? SEG : 1;
    localparam int TW       = F + 1;
    localparam int UW       = F + 4;
    localparam int PW       = 68;
    localparam int ZW       = PW - F + 1;
    localparam int LUT_SIZE = (1 << L) + 1;
    localparam int NCH      = (MAX_DEGREE < 2) ? 2 : MAX_DEGREE;
    localparam int NS       = NCH + 4;
    localparam int CH0      = 3;

    localparam logic [UW-1:0]  SEG_MASK = UW'((64'd1 << SEG) - 64'd1);
    localparam logic [ZW-1:0]  SIG_LIM  = ZW'(64'd8 << F);
    localparam logic [31:0]    ONE_Q    = 32'(64'd1 << F);
    localparam logic [31:0]    TOP      = 32'h8000_0000;
    localparam logic [3:0]     DEG_MAX  = 4'(MAX_DEGREE);

    typedef struct packed {
        logic                last;
        logic signed [34:0]  mb;
    } s0_t;

    typedef struct packed {
        logic                last;
        logic signed [PW-1:0] prod;
    } s1_t;

    typedef struct packed {
        logic          last;
        logic          zero;
        logic [UW-1:0] x;
        logic          zneg;
        logic          zbig;
        logic          sig_one;
        logic [31:0]   zm;
    } s2_t;

    typedef struct packed {
        logic           last;
        logic           zero;
        logic           zneg;
        logic           sig_one;
        logic [31:0]    zm;
        logic [31:0]    mag;
        logic           sat;
        logic [TW-1:0]  a;
        logic [TW-1:0]  diff;
        logic           desc;
        logic [FRW-1:0] fr;
        logic [TW-1:0]  step;
    } ch_t;

    typedef struct packed {
        logic signed [31:0] kernel_value;
        logic               saturated;
        logic               last_out;
    } res_t;

    logic [1:0]  kernel_kind_reg;
    logic [31:0] gamma_reg;
    logic [31:0] coef0_reg;
    logic [3:0]  degree_reg;
    logic [3:0]  deg_eff;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    s0_t  s0_reg, s0_next;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    ch_t  ch_reg [NCH];
    ch_t  ch_next [NCH];
    res_t res_reg, res_next;

    logic [TW-1:0] exp_rom  [LUT_SIZE];
    logic [TW-1:0] tanh_rom [LUT_SIZE];

    for (genvar i = 0; i < LUT_SIZE; i++)
    begin : g_rom
        localparam logic [TW-1:0] EXP_E  = TW'(tab_entry(F, L, i, 1'b0));
        localparam logic [TW-1:0] TANH_E = TW'(tab_entry(F, L, i, 1'b1));
        assign exp_rom[i]  = EXP_E;
        assign tanh_rom[i] = TANH_E;
    end

    // config
    assign cfg.ready = 1'b1;
    assign deg_eff   = (degree_reg > DEG_MAX) ? DEG_MAX : degree_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_kind_reg <= KIND_RBF;
            gamma_reg       <= 32'd65536;
            coef0_reg       <= 32'd0;
            degree_reg      <= 4'd3;
        end
        else if (cfg.valid)
        begin
            unique case (reg_idx_t'(cfg.index))
                REG_KIND:   kernel_kind_reg <= cfg.data[1:0];
                REG_GAMMA:  gamma_reg       <= cfg.data;
                REG_COEF0:  coef0_reg       <= cfg.data;
                REG_DEGREE: degree_reg      <= cfg.data[3:0];
            endcase
        end
    end

    // stage enables
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || result.ready;
        for (int i = NS - 2; i >= 0; i--)
            en[i] = !v_reg[i] || en[i+1];
    end

    assign item.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= item.valid;
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // S0: squared distance, multiplier operand
    always_comb
    begin
        logic signed [34:0] d;
        d = $signed({4'd0, item.row_norm}) + $signed({4'd0, item.col_norm})
            - $signed({{2{item.dot_value[31]}}, item.dot_value, 1'b0});
        s0_next.last = item.last_item;
        if (kernel_kind_reg == KIND_RBF)
            s0_next.mb = d[34] ? 35'sd0 : d;
        else
            s0_next.mb = 35'(item.dot_value);
    end

    // S1: gamma product
    always_comb
    begin
        s1_next.last = s0_reg.last;
        s1_next.prod = $signed({36'd0, gamma_reg}) * $signed({{33{s0_reg.mb[34]}}, s0_reg.mb});
    end

    // S2: scale, offset, magnitude
    always_comb
    begin
        logic signed [ZW-1:0] zs;
        logic        [ZW-1:0] zm;
        zs = ZW'($signed(s1_reg.prod[PW-1:F])) + ZW'($signed(coef0_reg));
        zm = zs[ZW-1] ? ZW'(-zs) : ZW'(zs);
        s2_next.last    = s1_reg.last;
        s2_next.zero    = |s1_reg.prod[PW-1:2*F+4];
        s2_next.x       = s1_reg.prod[2*F+3:F];
        s2_next.zneg    = zs[ZW-1];
        s2_next.zbig    = |zm[ZW-1:32];
        s2_next.sig_one = zm >= SIG_LIM;
        s2_next.zm      = zm[31:0];
    end

    // chain: one polynomial multiply per stage, table lookup in the first, interpolation step in the second
    for (genvar j = 0; j < NCH; j++)
    begin : g_ch
        always_comb
        begin
            ch_t           cin;
            logic [63:0]   p;
            logic [63:0]   pm;
            logic [UW-1:0] u;
            logic [L-1:0]  idx;
            logic [TW-1:0] ta;
            logic [TW-1:0] tb;
            logic [TW+FRW-1:0] sp;
            if (j == 0)
            begin
                cin         = '0;
                cin.last    = s2_reg.last;
                cin.zero    = s2_reg.zero;
                cin.zneg    = s2_reg.zneg;
                cin.sig_one = s2_reg.sig_one;
                cin.zm      = s2_reg.zm;
                cin.mag     = ONE_Q;
                cin.sat     = (deg_eff != 4'd0) && s2_reg.zbig;
            end
            else
                cin = ch_reg[(j == 0) ? 0 : j - 1];
            ch_next[j] = cin;

            p  = {32'd0, cin.mag} * {32'd0, cin.zm};
            pm = p >> F;
            if ((4'(j) < deg_eff) && !cin.sat)
            begin
                if (pm > {32'd0, TOP})
                    ch_next[j].sat = 1'b1;
                else
                    ch_next[j].mag = pm[31:0];
            end

            u   = (kernel_kind_reg == KIND_RBF) ? s2_reg.x : {s2_reg.zm[UW-2:0], 1'b0};
            idx = u[UW-1:SEG];
            if (kernel_kind_reg == KIND_RBF)
            begin
                ta = exp_rom[{1'b0, idx}];
                tb = exp_rom[(L+1)'(idx) + 1'b1];
            end
            else
            begin
                ta = tanh_rom[{1'b0, idx}];
                tb = tanh_rom[(L+1)'(idx) + 1'b1];
            end
            if (j == 0)
            begin
                ch_next[j].a    = ta;
                ch_next[j].desc = tb < ta;
                ch_next[j].diff = (tb < ta) ? ta - tb : tb - ta;
                ch_next[j].fr   = FRW'(u & SEG_MASK);
            end

            sp = {{FRW{1'b0}}, cin.diff} * {{TW{1'b0}}, cin.fr};
            if (j == 1)
                ch_next[j].step = TW'(sp >> SEG);
        end
    end

    // output selection
    always_comb
    begin
        ch_t                c;
        logic               neg;
        logic               psat;
        logic signed [31:0] pval;
        logic        [31:0] lv;
        logic signed [31:0] t;
        c    = ch_reg[NCH-1];
        neg  = c.zneg && deg_eff[0];
        psat = c.sat || (!neg && c.mag == TOP);
        if (psat)
            pval = neg ? $signed(TOP) : $signed(TOP - 32'd1);
        else
            pval = neg ? $signed(-c.mag) : $signed(c.mag);
        lv = c.desc ? 32'(c.a - c.step) : 32'(c.a + c.step);
        t  = c.sig_one ? $signed(ONE_Q) : $signed(lv);
        res_next.last_out  = c.last;
        res_next.saturated = 1'b0;
        case (kernel_kind_reg)
            KIND_RBF:  res_next.kernel_value = c.zero ? 32'sd0 : $signed(lv);
            KIND_POLY:
            begin
                res_next.kernel_value = pval;
                res_next.saturated    = psat;
            end
            KIND_SIG:  res_next.kernel_value = c.zneg ? -t : t;
            default:   res_next.kernel_value = 32'sd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            s0_reg <= s0_next;
        if (en[1])
            s1_reg <= s1_next;
        if (en[2])
            s2_reg <= s2_next;
        for (int j = 0; j < NCH; j++)
        begin
            if (en[CH0+j])
                ch_reg[j] <= ch_next[j];
        end
        if (en[NS-1])
            res_reg <= res_next;
    end

    assign result.valid        = v_reg[NS-1];
    assign result.kernel_value = res_reg.kernel_value;
    assign result.saturated    = res_reg.saturated;
    assign result.last_out     = res_reg.last_out;

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> v_reg[0])
        else $error("accepted word did not enter the pipeline");

    a_sat_poly_only: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.saturated |-> kernel_kind_reg == KIND_POLY)
        else $error("saturation outside polynomial kernel");

    a_rbf_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && kernel_kind_reg == KIND_RBF |-> !result.kernel_value[31])
        else $error("negative rbf kernel value");

    a_sig_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && kernel_kind_reg == KIND_SIG
        |-> result.kernel_value <= $signed(ONE_Q) && result.kernel_value >= -$signed(ONE_Q))
        else $error("sigmoid kernel value out of range");

endmodule

// ===== tb/tb_svm_kernel_value_transform.sv =====
// Testbench for svm_kernel_value_transform: directed and random words over all kernel
// kinds, checked against an in-bench fixed-point predictor with its own exp/tanh tables.
// Depends on skvt_pkg and the skvt_cfg_if, skvt_in_if and skvt_out_if interfaces.
module tb_svm_kernel_value_transform;
    timeunit 1ns;
    timeprecision 1ps;
    import skvt_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int FB = 16;
    localparam int LAB = 8;
    localparam int SEG = FB + 4 - LAB;
    localparam int NTAB = (1 << LAB) + 1;
    localparam longint unsigned ONE62 = 64'd1 << 62;

    typedef struct packed {
        logic signed [31:0] value;
        logic               sat;
        logic               last;
    } kword_t;

    class kernel_scoreboard;
        longint unsigned exp_lut[NTAB];
        longint unsigned tanh_lut[NTAB];
        logic [1:0]         kind;
        logic [31:0]        gamma_q;
        logic signed [31:0] coef0_q;
        logic [3:0]         degree_q;
        kword_t             pending[$];
        int                 mismatches;

        function new();
            longint unsigned term, stp, e, num, den;
            logic [127:0] p;
            term = ONE62;
            stp  = ONE62;
            e    = ONE62;
            for (longint unsigned k = 1; term != 0 && k < 64; k++)
            begin
                term = (term >> (LAB - 4)) / k;
                if (k[0]) stp = stp - term;
                else stp = stp + term;
            end
            for (int i = 0; i < NTAB; i++)
            begin
                if (i > 0)
                begin
                    p = {64'd0, e} * {64'd0, stp};
                    e = p[125:62];
                end
                exp_lut[i] = (e + (64'd1 << (61 - FB))) >> (62 - FB);
                num = (ONE62 - e) >> 24;
                den = (ONE62 + e) >> 24;
                tanh_lut[i] = ((num << FB) + den / 2) / den;
            end
            kind = KIND_RBF;
            gamma_q = 32'd65536;
            coef0_q = 0;
            degree_q = 4'd3;
            mismatches = 0;
        endfunction

        function longint unsigned interp(bit use_tanh, longint unsigned u);
            longint unsigned idx, fr, a, b;
            idx = (u >> SEG) & ((1 << LAB) - 1);
            fr  = u & ((64'd1 << SEG) - 1);
            a = use_tanh ? tanh_lut[idx] : exp_lut[idx];
            b = use_tanh ? tanh_lut[idx + 1] : exp_lut[idx + 1];
            if (b >= a) return a + (((b - a) * fr) >> SEG);
            return a - (((a - b) * fr) >> SEG);
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] d);
            case (idx)
                REG_KIND:   kind = d[1:0];
                REG_GAMMA:  gamma_q = d;
                REG_COEF0:  coef0_q = d;
                REG_DEGREE: degree_q = d[3:0];
            endcase
        endfunction

        function void note_input(logic [30:0] rn, logic [30:0] cn, logic signed [31:0] dot,
                                 logic last);
            longint z, d, g, v;
            longint unsigned ud, zm, mag, lim, top, t;
            int deg;
            bit neg, sat;
            kword_t w;
            g = longint'({32'd0, gamma_q});
            z = ((g * longint'(dot)) >>> FB) + longint'(coef0_q);
            sat = 0;
            v = 0;
            lim = 64'd16 << FB;
            top = 64'd1 << 31;
            case (kind)
                KIND_RBF:
                begin
                    d = longint'({33'd0, rn}) + longint'({33'd0, cn}) - 2 * longint'(dot);
                    if (d < 0) d = 0;
                    ud = d;
                    if (gamma_q != 0 && ud > ((lim << FB) - 1) / gamma_q) v = 0;
                    else if (((g * ud) >> FB) >= lim) v = 0;
                    else v = interp(0, (g * ud) >> FB);
                end
                KIND_POLY:
                begin
                    deg = degree_q > 8 ? 8 : degree_q;
                    neg = (z < 0) && deg[0];
                    zm = z < 0 ? -z : z;
                    mag = 64'd1 << FB;
                    if (deg != 0)
                    begin
                        if (zm >= (64'd1 << 32)) sat = 1;
                        else
                        begin
                            for (int k = 0; k < deg && !sat; k++)
                            begin
                                mag = (mag * zm) >> FB;
                                if (mag > top) sat = 1;
                            end
                            if (!neg && mag == top) sat = 1;
                        end
                    end
                    if (sat) v = neg ? -longint'(top) : longint'(top - 1);
                    else v = neg ? -longint'(mag) : longint'(mag);
                end
                KIND_SIG:
                begin
                    zm = z < 0 ? -z : z;
                    t = zm >= (64'd8 << FB) ? 64'd1 << FB : interp(1, 2 * zm);
                    v = z < 0 ? -longint'(t) : longint'(t);
                end
                default: v = 0;
            endcase
            w.value = v[31:0];
            w.sat = sat;
            w.last = last;
            pending = {pending, w};
        endfunction

        function void check(logic signed [31:0] kv, logic s, logic l);
            kword_t w;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", kv);
                return;
            end
            w = pending.pop_front();
            if (w.value !== kv || w.sat !== s || w.last !== l)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp value %h sat %b last %b, got %h %b %b",
                             w.value, w.sat, w.last, kv, s, l);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    skvt_cfg_if cfg ();
    skvt_in_if  item ();
    skvt_out_if result ();
    kernel_scoreboard sb;
    int hold_off;
    bit out_stall_mode;
    int n_words;

    svm_kernel_value_transform i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .result (result)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("svm_kernel_value_transform verification failed");
        $finish;
    end

    // Receiver: random stalls in stretches, plus one long hold-off.
    initial
    begin
        result.ready = 0;
        forever
        begin
            @(posedge clk);
            if (result.valid && result.ready)
                sb.check(result.kernel_value, result.saturated, result.last_out);
            if ($urandom_range(0, 99) == 0) out_stall_mode = ~out_stall_mode;
            if (hold_off > 0)
            begin
                hold_off--;
                result.ready <= 0;
            end
            else
                result.ready <= out_stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
        end
    end

    task automatic wait_idle();
        int guard;
        guard = 0;
        item.valid <= 0;
        while (sb.pending.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] d);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data  <= d;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 0;
        sb.set_reg(idx, d);
        @(posedge clk);
    endtask

    task automatic set_all(logic [1:0] k, logic [31:0] g, logic [31:0] c, logic [3:0] dg);
        wait_idle();
        write_reg(REG_KIND, {30'd0, k});
        write_reg(REG_GAMMA, g);
        write_reg(REG_COEF0, c);
        write_reg(REG_DEGREE, {28'd0, dg});
    endtask

    task automatic send_word(logic [30:0] rn, logic [30:0] cn, logic signed [31:0] dot,
                             logic last, int gap);
        item.valid     <= 1;
        item.row_norm  <= rn;
        item.col_norm  <= cn;
        item.dot_value <= dot;
        item.last_item <= last;
        do @(posedge clk); while (!item.ready);
        sb.note_input(rn, cn, dot, last);
        n_words++;
        if (gap > 0)
        begin
            item.valid <= 0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random();
        logic [30:0] rn, cn;
        logic signed [31:0] dot;
        int gap;
        case ($urandom_range(0, 3))
            0:
            begin
                rn = 31'($urandom);
                cn = 31'($urandom);
                dot = $urandom;
            end
            1:
            begin
                rn = 31'($urandom_range(0, 1 << 20));
                cn = 31'($urandom_range(0, 1 << 20));
                dot = (rn + cn) / 2 - $urandom_range(0, 1 << 18);
            end
            default:
            begin
                rn = 31'($urandom_range(0, 1 << 19));
                cn = 31'($urandom_range(0, 1 << 19));
                dot = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            end
        endcase
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        send_word(rn, cn, dot, 1'($urandom_range(0, 1)), gap);
    endtask

    function automatic logic [31:0] pick_gamma();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return 32'd65536;
            3: return $urandom;
            default: return $urandom_range(1, 1 << 18);
        endcase
    endfunction

    function automatic logic [31:0] pick_coef0();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 0;
            3: return $urandom;
            default: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
        endcase
    endfunction

    initial
    begin
        logic [1:0] k;
        int burst;
        sb = new();
        hold_off = 0;
        out_stall_mode = 0;
        n_words = 0;
        rst_n = 0;
        cfg.valid = 0;
        cfg.index = REG_KIND;
        cfg.data = 0;
        item.valid = 0;
        item.row_norm = 0;
        item.col_norm = 0;
        item.dot_value = 0;
        item.last_item = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        repeat (4) @(posedge clk);

        // reset config: rbf, gamma 1.0
        send_word(0, 0, 0, 0, 0);
        send_word(31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'sh8000_0000, 1, 0);
        send_word(0, 0, 32'sh7FFF_FFFF, 0, 1);
        send_word(31'd65536, 31'd65536, 32'sd65536, 1, 0);
        send_word(31'd1 << 20, 0, 0, 0, 0);
        send_word(31'd100000, 31'd30000, 32'sd20000, 1, 2);
        set_all(KIND_POLY, 32'd65536, 32'd65536, 4'd0);
        send_word(0, 0, 32'sh8000_0000, 1, 0);
        wait_idle();
        write_reg(REG_DEGREE, 32'd15);
        send_word(0, 0, 32'sh7FFF_FFFF, 0, 0);
        send_word(0, 0, -32'sd3 <<< 16, 1, 0);
        send_word(0, 0, 32'sd1 << 15, 0, 0);
        set_all(KIND_POLY, 32'hFFFF_FFFF, 32'h8000_0000, 4'd3);
        send_word(0, 0, 32'sh8000_0000, 0, 0);
        send_word(0, 0, 32'sh7FFF_FFFF, 1, 0);
        send_word(0, 0, 0, 0, 0);
        set_all(KIND_SIG, 32'd65536, 32'h7FFF_FFFF, 4'd3);
        send_word(0, 0, 32'sh7FFF_FFFF, 0, 0);
        wait_idle();
        write_reg(REG_COEF0, 32'd0);
        send_word(0, 0, -32'sd70000, 1, 0);
        send_word(0, 0, 32'sd8 <<< 16, 0, 0);
        send_word(0, 0, 32'sd123456, 0, 0);
        set_all(KIND_UNUSED, 32'd65536, 32'd0, 4'd3);
        send_word(31'd5, 31'd7, 32'sd9, 1, 0);
        send_word(31'h7FFF_FFFF, 0, 32'sh8000_0000, 0, 0);

        for (int ph = 0; ph < 16; ph++)
        begin
            k = ($urandom_range(0, 9) == 0) ? KIND_UNUSED : 2'($urandom_range(0, 2));
            set_all(k, pick_gamma(), pick_coef0(), 4'($urandom_range(0, 15)));
            if (ph == 5) hold_off = 300;
            burst = 0;
            for (int n = 0; n < 120; n++)
            begin
                send_random();
                burst++;
                if (burst > $urandom_range(4, 40))
                begin
                    burst = 0;
                    item.valid <= 0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
                if (ph == 9 && n == 60) wait_idle();
            end
        end

        wait_idle();
        repeat (30) @(posedge clk);
        $display("covered %0d words over rbf, polynomial, sigmoid and unused kinds", n_words);
        $display("with extreme gamma, coef0 and degree settings and output back-pressure");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("svm_kernel_value_transform verification clean");
        else
            $display("svm_kernel_value_transform verification failed");
        $finish;
    end
endmodule

// ===== files.f =====
src/skvt_pkg.sv
src/skvt_cfg_if.sv
src/skvt_in_if.sv
src/skvt_out_if.sv
src/svm_kernel_value_transform.sv
tb/tb_svm_kernel_value_transform.sv
